// ===== sv/strip_to_list_degenerate_cull_top_macros.svh =====
`ifndef STRIP_TO_LIST_DEGENERATE_CULL_TOP_MACROS_SVH
`define STRIP_TO_LIST_DEGENERATE_CULL_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define STDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define STDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stdc_pkg.sv =====
package stdc_pkg;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 24;
  localparam int TEX_W  = 16;
  localparam int AREA_W = 24;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam logic [AREA_W-1:0] MIN_AREA_RESET = AREA_W'(4);

  // vertex word: {uv_negative, z, y, x}
  localparam int VTX_W = 3 * POS_W + 1;

  localparam int DIFF_W  = POS_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int THR_W   = 2 * AREA_W;
  localparam int AREA_SHIFT = 26;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_STRIP = 1'b1
  } stdc_func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_MUL,
    ST_SUB,
    ST_ABS,
    ST_SQ,
    ST_ACC1,
    ST_ACC2,
    ST_CMP
  } stdc_state_t;

  typedef enum logic [1:0] {
    RD_SEL_A,
    RD_SEL_B,
    RD_SEL_C
  } stdc_rd_sel_t;

  typedef struct packed {
    logic         in_ready;
    stdc_rd_sel_t rd_sel;
    logic         cap_a;
    logic         cap_u;
    logic         cap_v;
    logic         en_mul;
    logic         en_sub;
    logic         en_abs;
    logic         en_sq;
    logic         en_acc1;
    logic         en_acc2;
    logic         out_load;
  } stdc_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic tri_go;
    logic pass;
    logic out_free;
  } stdc_sts_t;

endpackage

// ===== sv/stdc_in_if.sv =====
interface stdc_in_if;
  import stdc_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [TEX_W-1:0] tex_u;
  logic signed [TEX_W-1:0] tex_v;
  logic              strip_restart;

  modport source (
    output valid, func, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, strip_restart,
    input  ready
  );
  modport sink (
    input  valid, func, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, strip_restart,
    output ready
  );
endinterface

// ===== sv/stdc_out_if.sv =====
interface stdc_out_if;
  import stdc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;

  modport source (
    output valid, corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

// ===== sv/strip_to_list_degenerate_cull_top.sv =====
// Triangle-strip to triangle-list converter with degenerate, negative-uv and small-area cull.
// A load item (func 0) writes one vertex into the table in its transfer cycle; a
// strip item that forms no triangle to test (first two indices of a strip,
// repeated index, index beyond the table) also leaves the input ready, so such
// items may arrive back to back. A strip item that forms a candidate triangle
// holds the input off while it is worked on: three reads through the single
// read port of the vertex RAM, then the cross-product and squared-magnitude
// pipeline, then the threshold compare. A kept triangle waits in the output
// register, and new items are taken while it waits; only a second kept triangle
// stalls, in the compare step, until the first is transferred. Table entries are
// undefined until loaded and there is no clearing pass after reset.
module strip_to_list_degenerate_cull_top #(
  parameter int VERTEX_DEPTH = stdc_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stdc_in_if.sink                     in_ch,
  stdc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [stdc_pkg::AREA_W-1:0] cfg_wdata
);
  import stdc_pkg::*;

  `include "strip_to_list_degenerate_cull_top_macros.svh"

  stdc_cmd_t cmd;
  stdc_sts_t sts;

  stdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  stdc_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  `STDC_ASSERT_NEXT(a_busy_after_tri, clk, rst_n, in_ch.valid && in_ch.ready && sts.tri_go, !in_ch.ready, "input not held off after a candidate triangle")
  `STDC_ASSERT_SAME(a_out_distinct, clk, rst_n, out_ch.valid, (out_ch.corner_a != out_ch.corner_b) && (out_ch.corner_a != out_ch.corner_c) && (out_ch.corner_b != out_ch.corner_c), "degenerate triangle on output")
  `STDC_ASSERT_SAME(a_load_ok, clk, rst_n, cmd.out_load, sts.out_free && !cmd.in_ready, "result loaded over a waiting result or while idle")
endmodule

// ===== sv/stdc_ram.sv =====
module stdc_ram #(
  parameter int WIDTH = stdc_pkg::VTX_W,
  parameter int DEPTH = stdc_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/stdc_ctrl.sv =====
module stdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  stdc_pkg::stdc_sts_t sts,
  output stdc_pkg::stdc_cmd_t cmd
);
  import stdc_pkg::*;

  stdc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_SEL_A;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid && sts.tri_go) begin
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_sel = RD_SEL_A;
        state_nxt  = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_sel = RD_SEL_B;
        cmd.cap_a  = 1'b1;
        state_nxt  = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_sel = RD_SEL_C;
        cmd.cap_u  = 1'b1;
        state_nxt  = ST_RD_D;
      end
      ST_RD_D: begin
        cmd.cap_v = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.en_mul = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        cmd.en_sub = 1'b1;
        state_nxt  = ST_ABS;
      end
      ST_ABS: begin
        cmd.en_abs = 1'b1;
        state_nxt  = ST_SQ;
      end
      ST_SQ: begin
        cmd.en_sq = 1'b1;
        state_nxt = ST_ACC1;
      end
      ST_ACC1: begin
        cmd.en_acc1 = 1'b1;
        state_nxt   = ST_ACC2;
      end
      ST_ACC2: begin
        cmd.en_acc2 = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        // a passing triangle waits here until the output register can take it
        if (!sts.pass) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== sv/stdc_dp.sv =====
module stdc_dp #(
  parameter int VERTEX_DEPTH = stdc_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  stdc_in_if.sink                    in_ch,
  stdc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [stdc_pkg::AREA_W-1:0] cfg_wdata,
  input  stdc_pkg::stdc_cmd_t        cmd,
  output stdc_pkg::stdc_sts_t        sts
);
  import stdc_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  logic [AREA_W-1:0] min_area_r;

  // strip window
  logic [IDX_W-1:0] older_r, newer_r;
  logic [1:0]       fill_r;

  // triangle in flight
  logic [IDX_W-1:0] tri_a_r, tri_b_r, tri_c_r;

  logic accept, is_strip;
  logic a_in, b_in, c_in, idx_in;
  logic [31:0] idx_wide, rd_wide;
  logic [IDX_W-1:0] rd_idx;

  logic            ram_we;
  logic [AW-1:0]   waddr, raddr;
  logic [VTX_W-1:0] wdata, rdata;

  logic signed [POS_W-1:0]  rd_x, rd_y, rd_z;
  logic                     rd_neg;
  logic signed [POS_W-1:0]  ax_r, ay_r, az_r;
  logic                     neg_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PROD_W-1:0] prod_r [6];
  logic [THR_W-1:0]         thr_r;
  logic signed [CROSS_W-1:0] cross_r [3];
  logic [MAG_W-1:0]          mag_r [3];
  logic [PROD_W-1:0]         hh_r [3];
  logic [PROD_W-1:0]         hl_r [3];
  logic [PROD_W-1:0]         ll_r [3];
  logic [SQ_W-1:0]           sq_r [3];
  logic [SUM_W-1:0]          total_r;
  logic [SUM_W-1:0]          thr_full;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_a_r, out_b_r, out_c_r;

  assign in_ch.ready = cmd.in_ready;
  assign accept      = in_ch.valid && cmd.in_ready;
  assign is_strip    = (in_ch.func == FUNC_STRIP);

  assign a_in   = 32'(older_r) < 32'(VERTEX_DEPTH);
  assign b_in   = 32'(newer_r) < 32'(VERTEX_DEPTH);
  assign idx_in = 32'(in_ch.vertex_index) < 32'(VERTEX_DEPTH);
  assign c_in   = idx_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_area_r <= MIN_AREA_RESET;
    end else if (cfg_we) begin
      min_area_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      fill_r  <= '0;
    end else if (accept && is_strip) begin
      older_r <= newer_r;
      newer_r <= in_ch.vertex_index;
      if (in_ch.strip_restart) begin
        fill_r <= 2'd1;
      end else if (fill_r != 2'd2) begin
        fill_r <= fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tri_a_r <= older_r;
      tri_b_r <= newer_r;
      tri_c_r <= in_ch.vertex_index;
    end
  end

  // vertex table
  assign idx_wide = 32'(in_ch.vertex_index);
  assign waddr    = idx_wide[AW-1:0];
  assign ram_we   = accept && !is_strip && idx_in;
  assign wdata    = {(in_ch.tex_u[TEX_W-1] | in_ch.tex_v[TEX_W-1]),
                     in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};

  always_comb begin
    case (cmd.rd_sel)
      RD_SEL_A: rd_idx = tri_a_r;
      RD_SEL_B: rd_idx = tri_b_r;
      RD_SEL_C: rd_idx = tri_c_r;
      default:  rd_idx = tri_a_r;
    endcase
  end
  assign rd_wide = 32'(rd_idx);
  assign raddr   = rd_wide[AW-1:0];

  stdc_ram #(
    .WIDTH (VTX_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_x   = rdata[POS_W-1:0];
  assign rd_y   = rdata[2*POS_W-1:POS_W];
  assign rd_z   = rdata[3*POS_W-1:2*POS_W];
  assign rd_neg = rdata[VTX_W-1];

  // edge vectors u = B - A, v = C - A
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      ax_r  <= rd_x;
      ay_r  <= rd_y;
      az_r  <= rd_z;
      neg_r <= rd_neg;
    end
    if (cmd.cap_u) begin
      ux_r  <= DIFF_W'(rd_x) - DIFF_W'(ax_r);
      uy_r  <= DIFF_W'(rd_y) - DIFF_W'(ay_r);
      uz_r  <= DIFF_W'(rd_z) - DIFF_W'(az_r);
      neg_r <= neg_r | rd_neg;
    end
    if (cmd.cap_v) begin
      vx_r  <= DIFF_W'(rd_x) - DIFF_W'(ax_r);
      vy_r  <= DIFF_W'(rd_y) - DIFF_W'(ay_r);
      vz_r  <= DIFF_W'(rd_z) - DIFF_W'(az_r);
      neg_r <= neg_r | rd_neg;
    end
  end

  // cross product, then |cross|^2 from 25-bit halves
  always_ff @(posedge clk) begin
    if (cmd.en_mul) begin
      prod_r[0] <= PROD_W'(uy_r) * PROD_W'(vz_r);
      prod_r[1] <= PROD_W'(uz_r) * PROD_W'(vy_r);
      prod_r[2] <= PROD_W'(uz_r) * PROD_W'(vx_r);
      prod_r[3] <= PROD_W'(ux_r) * PROD_W'(vz_r);
      prod_r[4] <= PROD_W'(ux_r) * PROD_W'(vy_r);
      prod_r[5] <= PROD_W'(uy_r) * PROD_W'(vx_r);
      thr_r     <= THR_W'(min_area_r) * THR_W'(min_area_r);
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.en_sub) begin
        cross_r[i] <= CROSS_W'(prod_r[2*i]) - CROSS_W'(prod_r[2*i+1]);
      end
      if (cmd.en_abs) begin
        mag_r[i] <= cross_r[i][CROSS_W-1] ? MAG_W'(-cross_r[i]) : MAG_W'(cross_r[i]);
      end
      if (cmd.en_sq) begin
        hh_r[i] <= PROD_W'(mag_r[i][MAG_W-1:HALF_W]) * PROD_W'(mag_r[i][MAG_W-1:HALF_W]);
        hl_r[i] <= PROD_W'(mag_r[i][MAG_W-1:HALF_W]) * PROD_W'(mag_r[i][HALF_W-1:0]);
        ll_r[i] <= PROD_W'(mag_r[i][HALF_W-1:0]) * PROD_W'(mag_r[i][HALF_W-1:0]);
      end
      if (cmd.en_acc1) begin
        // hi^2 * 2^50 + 2 * hi * lo * 2^25 + lo^2
        sq_r[i] <= {hh_r[i], {PROD_W{1'b0}}}
                 + {{(SQ_W-PROD_W-HALF_W-1){1'b0}}, hl_r[i], {(HALF_W+1){1'b0}}}
                 + {{(SQ_W-PROD_W){1'b0}}, ll_r[i]};
      end
    end
    if (cmd.en_acc2) begin
      total_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  assign thr_full = {{(SUM_W-THR_W-AREA_SHIFT){1'b0}}, thr_r, {AREA_SHIFT{1'b0}}};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_a_r <= tri_a_r;
      out_b_r <= tri_b_r;
      out_c_r <= tri_c_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.corner_a = out_a_r;
  assign out_ch.corner_b = out_b_r;
  assign out_ch.corner_c = out_c_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.tri_go   = is_strip && !in_ch.strip_restart && (fill_r == 2'd2)
                     && (older_r != newer_r) && (older_r != in_ch.vertex_index)
                     && (newer_r != in_ch.vertex_index) && a_in && b_in && c_in;
  assign sts.pass     = !neg_r && (total_r > thr_full);
  assign sts.out_free = !out_valid_r || out_ch.ready;
endmodule

// ===== tb/strip_to_list_degenerate_cull_top_tb.sv =====
module strip_to_list_degenerate_cull_top_tb;
  import stdc_pkg::*;

  localparam int PHASE_ITEMS = 375;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    stdc_func_t              func;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [TEX_W-1:0] tex_u;
    logic signed [TEX_W-1:0] tex_v;
    logic                    strip_restart;
  } strip_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } corner_set_t;

  class strip_cull_scoreboard;
    logic signed [POS_W-1:0] x_tab [VERTEX_DEPTH_DEF];
    logic signed [POS_W-1:0] y_tab [VERTEX_DEPTH_DEF];
    logic signed [POS_W-1:0] z_tab [VERTEX_DEPTH_DEF];
    bit                      uv_neg [VERTEX_DEPTH_DEF];
    logic [IDX_W-1:0]        older;
    logic [IDX_W-1:0]        newer;
    int unsigned             fill;
    logic [AREA_W-1:0]       min_area;
    corner_set_t             pending_triangles[$];
    int                      errors;

    function new();
      older    = '0;
      newer    = '0;
      fill     = 0;
      min_area = MIN_AREA_RESET;
      errors   = 0;
    endfunction

    // |cross|^2 against min_area^2 * 2^26, all unsigned at 128 bits
    function bit area_above(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                            logic [IDX_W-1:0] c);
      longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
      logic [127:0] mx, my, mz, lim;
      ux = longint'(x_tab[b]) - longint'(x_tab[a]);
      uy = longint'(y_tab[b]) - longint'(y_tab[a]);
      uz = longint'(z_tab[b]) - longint'(z_tab[a]);
      wx = longint'(x_tab[c]) - longint'(x_tab[a]);
      wy = longint'(y_tab[c]) - longint'(y_tab[a]);
      wz = longint'(z_tab[c]) - longint'(z_tab[a]);
      cx = uy * wz - uz * wy;
      cy = uz * wx - ux * wz;
      cz = ux * wy - uy * wx;
      if (cx < 0) cx = -cx;
      if (cy < 0) cy = -cy;
      if (cz < 0) cz = -cz;
      mx = 128'(cx);
      my = 128'(cy);
      mz = 128'(cz);
      lim = 128'(min_area);
      lim = (lim * lim) << AREA_SHIFT;
      return (mx * mx + my * my + mz * mz) > lim;
    endfunction

    function void note_item(strip_item_t it);
      corner_set_t t;
      bit keep;
      if (it.func == FUNC_LOAD) begin
        x_tab[it.vertex_index]  = it.pos_x;
        y_tab[it.vertex_index]  = it.pos_y;
        z_tab[it.vertex_index]  = it.pos_z;
        uv_neg[it.vertex_index] = it.tex_u[TEX_W-1] | it.tex_v[TEX_W-1];
        return;
      end
      if (it.strip_restart) fill = 0;
      if (fill >= 2) begin
        t.a = older;
        t.b = newer;
        t.c = it.vertex_index;
        keep = (t.a != t.b) && (t.a != t.c) && (t.b != t.c);
        // uv and area only looked at once the corners are distinct
        if (keep)
          keep = !uv_neg[t.a] && !uv_neg[t.b] && !uv_neg[t.c] &&
                 area_above(t.a, t.b, t.c);
        if (keep) pending_triangles.push_back(t);
      end else begin
        fill++;
      end
      older = newer;
      newer = it.vertex_index;
    endfunction

    function void check_triangle(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                 logic [IDX_W-1:0] c);
      corner_set_t want;
      if (pending_triangles.size() == 0) begin
        $error("triangle %0d %0d %0d with none pending", a, b, c);
        errors++;
        return;
      end
      want = pending_triangles.pop_front();
      if (want.a !== a) begin
        $error("corner_a mismatch: expected %0d, actual %0d", want.a, a);
        errors++;
      end
      if (want.b !== b) begin
        $error("corner_b mismatch: expected %0d, actual %0d", want.b, b);
        errors++;
      end
      if (want.c !== c) begin
        $error("corner_c mismatch: expected %0d, actual %0d", want.c, c);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [AREA_W-1:0] cfg_wdata;

  stdc_in_if  in_ch ();
  stdc_out_if out_ch ();

  strip_to_list_degenerate_cull_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  strip_cull_scoreboard sb = new();

  int burst_left = 0;
  int kept_seen = 0;
  int pool [4][$];   // loaded indices, grouped by position scale
  int gen_older = 0;
  int gen_newer = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin : monitor
    strip_item_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_triangle(out_ch.corner_a, out_ch.corner_b, out_ch.corner_c);
        kept_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.func          = stdc_func_t'(in_ch.func);
        seen.vertex_index  = in_ch.vertex_index;
        seen.pos_x         = in_ch.pos_x;
        seen.pos_y         = in_ch.pos_y;
        seen.pos_z         = in_ch.pos_z;
        seen.tex_u         = in_ch.tex_u;
        seen.tex_v         = in_ch.tex_v;
        seen.strip_restart = in_ch.strip_restart;
        sb.note_item(seen);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: stall patterns, plus one long hold-off to back the block up
  initial begin : receiver
    int mode, span, n;
    bit held;
    held = 1'b0;
    n = 0;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        if (!held && kept_seen >= 60) begin
          out_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          held = 1'b1;
        end
        n++;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = ((n % 7) < 5);
        endcase
      end
    end
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer(strip_item_t it);
    pace();
    in_ch.valid         = 1'b1;
    in_ch.func          = it.func;
    in_ch.vertex_index  = it.vertex_index;
    in_ch.pos_x         = it.pos_x;
    in_ch.pos_y         = it.pos_y;
    in_ch.pos_z         = it.pos_z;
    in_ch.tex_u         = it.tex_u;
    in_ch.tex_v         = it.tex_v;
    in_ch.strip_restart = it.strip_restart;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic put_vertex(int idx, int x, int y, int z, int u, int v, int cls,
                            bit restart);
    strip_item_t it;
    it.func          = FUNC_LOAD;
    it.vertex_index  = IDX_W'(idx);
    it.pos_x         = POS_W'(x);
    it.pos_y         = POS_W'(y);
    it.pos_z         = POS_W'(z);
    it.tex_u         = TEX_W'(u);
    it.tex_v         = TEX_W'(v);
    it.strip_restart = restart;
    pool[cls].push_back(idx);
    offer(it);
  endtask

  task automatic put_index(int idx, bit restart);
    strip_item_t it;
    it.func          = FUNC_STRIP;
    it.vertex_index  = IDX_W'(idx);
    it.pos_x         = POS_W'($urandom);
    it.pos_y         = POS_W'($urandom);
    it.pos_z         = POS_W'($urandom);
    it.tex_u         = TEX_W'($urandom);
    it.tex_v         = TEX_W'($urandom);
    it.strip_restart = restart;
    offer(it);
  endtask

  function automatic int tex_value();
    if ($urandom_range(0, 9) == 0) return -int'($urandom_range(1, 32768));
    return int'($urandom_range(0, 32767));
  endfunction

  function automatic int pick_from(int cls);
    return pool[cls][$urandom_range(0, pool[cls].size() - 1)];
  endfunction

  task automatic new_vertex();
    int cls, idx, k, p[3];
    bit on_line;
    cls = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0 && pool[cls].size() > 0)
      idx = pick_from(cls);
    else
      idx = $urandom_range(0, VERTEX_DEPTH_DEF - 1);
    k = int'($urandom_range(0, 8)) - 4;
    on_line = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      case (cls)
        0: p[i] = $urandom;
        1: p[i] = int'($urandom_range(0, 32767)) - 16384;
        2: p[i] = int'($urandom_range(0, 1023)) - 512;
        // tiny: half of these sit on one line through the origin
        default: p[i] = on_line ? k * (i + 1) : int'($urandom_range(0, 8)) - 4;
      endcase
    end
    put_vertex(idx, p[0], p[1], p[2], tex_value(), tex_value(), cls,
               1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(int n);
    int sent, len, cls, alt, r, idx;
    bit restart;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          new_vertex();
          sent++;
        end
      end
      cls = $urandom_range(0, 3);
      while (pool[cls].size() < 3) cls = (cls + 1) % 4;
      len = $urandom_range(1, 14);
      // occasionally carry on without a restart
      restart = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          new_vertex();
          sent++;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
          idx = gen_newer;
        end else if (r == 1) begin
          idx = gen_older;
        end else if (r <= 3) begin
          alt = $urandom_range(0, 3);
          if (pool[alt].size() == 0) alt = 2;
          idx = pick_from(alt);
        end else begin
          idx = pick_from(cls);
        end
        put_index(idx, restart && k == 0);
        gen_older = gen_newer;
        gen_newer = idx;
        sent++;
      end
    end
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending_triangles.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_min_area(logic [AREA_W-1:0] v);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.min_area = v;
  endtask

  initial begin : stimulus
    logic [AREA_W-1:0] thr_list [4];
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_LOAD;
    in_ch.vertex_index  = '0;
    in_ch.pos_x         = '0;
    in_ch.pos_y         = '0;
    in_ch.pos_z         = '0;
    in_ch.tex_u         = '0;
    in_ch.tex_v         = '0;
    in_ch.strip_restart = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: threshold exactly met, just passed, extremes, uv and repeats
    put_vertex(0, 0, 0, 0, 0, 0, 2, 1'b0);
    put_vertex(1, 8192, 0, 0, 32767, 0, 2, 1'b0);
    put_vertex(2, 0, 4, 0, 0, 32767, 2, 1'b0);
    put_vertex(3, 0, 5, 0, 1, 1, 2, 1'b0);
    put_vertex(4095, 8388607, -8388608, 8388607, 32767, 32767, 0, 1'b0);
    put_vertex(12'h555, -8388608, 8388607, -8388608, -32768, 0, 0, 1'b0);
    put_vertex(12'hAAA, 1, 1, 1, 0, -1, 0, 1'b0);
    put_index(0, 1'b1);
    put_index(1, 1'b0);
    put_index(2, 1'b0);      // area equal to threshold: dropped
    put_index(1, 1'b1);
    put_index(0, 1'b0);
    put_index(3, 1'b0);      // just above threshold
    put_index(4095, 1'b0);
    put_index(12'h555, 1'b0);
    put_index(12'hAAA, 1'b0);
    put_index(12'hAAA, 1'b0);
    put_vertex(5, 0, 0, 0, 100, 200, 2, 1'b1);   // restart ignored on a load
    put_index(0, 1'b0);
    put_index(5, 1'b1);
    put_index(0, 1'b0);
    put_index(4095, 1'b0);   // two corners coincide: zero area
    gen_older = 0;
    gen_newer = 4095;

    random_phase(PHASE_ITEMS);

    thr_list[0] = '0;
    thr_list[1] = '1;
    thr_list[2] = AREA_W'($urandom_range(1, 65535));
    thr_list[3] = AREA_W'($urandom);
    foreach (thr_list[i]) begin
      settle();
      set_min_area(thr_list[i]);
      random_phase(PHASE_ITEMS);
    end
    settle();

    if (sb.errors == 0 && sb.pending_triangles.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
